>>> hdl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes for the linear probing hash table: item structs,
// command and status codes, and the controller state encoding.
// ----------------------------------------------------------------------------
package lph_pkg;

   // default table size
   localparam int TABLE_ENTRIES_DEFAULT = 16;

   // field widths
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd4;

   // request item
   typedef struct packed {
      logic [1:0]                command;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   // response item
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] found_value;
      logic [SLOT_W-1:0]         slot;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_MUL_Q,
      S_MUL_R,
      S_HOME,
      S_PROBE,
      S_CLEAR,
      S_FLUSH
   } state_type;

endpackage

>>> hdl/linear_probe_hash_table.sv
// Insert/search probe p slots from the home slot, p being 1..TABLE_ENTRIES,
//   one probe per cycle out of the RAM.
// Clear writes one RAM entry per slot; unused command 3.
// One item in flight; the next item is accepted once the response is registered.
// Reset: synchronous; an init sweep over all TABLE_ENTRIES slots clears the used bits,
//   during which no item is accepted.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/value table with linear probing. Entries {used, key,
// value} live in one RAM; home slot is key mod TABLE_ENTRIES via reciprocal
// multiply, probing reads one slot per cycle with the read pipelined ahead.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_ENTRIES = lph_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lph_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lph_pkg::rsp_type rsp_data
);

   localparam int KW = lph_pkg::KEY_W;
   localparam int VW = lph_pkg::VALUE_W;
   localparam int EW = 1 + KW + VW;
   localparam int SW = $clog2(TABLE_ENTRIES);
   localparam int RW = SW + 1;

   localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_ENTRIES - 1);
   localparam logic [RW-1:0] N_R       = RW'(TABLE_ENTRIES);
   // floor(2^32 / N): quotient estimate is exact or one low
   localparam logic [32:0]   RECIP_WIDE = 33'h1_0000_0000 / TABLE_ENTRIES;
   localparam logic [31:0]   RECIP      = RECIP_WIDE[31:0];

   // registers
   lph_pkg::state_type  state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [VW-1:0]       value_ff, value_in;
   logic [KW-1:0]       q_ff, q_in;
   logic [RW-1:0]       prod_ff, prod_in;
   logic [SW-1:0]       issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SW-1:0]       rd_slot_ff, rd_slot_in;
   logic [SW-1:0]       cnt_ff, cnt_in;
   lph_pkg::rsp_type    res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lph_pkg::rsp_type    rsp_ff, rsp_in;

   // RAM ports
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [SW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   // datapath helpers
   logic [63:0]   mul_q;
   logic [RW-1:0] rem_raw;
   logic [RW-1:0] home;
   logic          ent_used;
   logic [KW-1:0] ent_key;
   logic [VW-1:0] ent_value;
   logic          req_acc;
   logic          out_free;
   logic          probe_done;
   logic          lap_done;
   logic          sweep_done;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SW'(1);
   endfunction

   lph_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshakes
   assign req_stall = (state_ff != lph_pkg::S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // home slot: quotient estimate, then remainder below 2N, one correction
   assign mul_q   = {33'd0, key_ff} * {32'd0, RECIP};
   assign rem_raw = key_ff[RW-1:0] - prod_ff;
   assign home    = (rem_raw >= N_R) ? rem_raw - N_R : rem_raw;

   // entry fields of the slot read last cycle
   assign ent_used  = rd_data[EW-1];
   assign ent_key   = rd_data[EW-2 -: KW];
   assign ent_value = rd_data[VW-1:0];

   // probe resolution
   assign lap_done   = (cnt_ff == LAST_SLOT);
   assign sweep_done = (cnt_ff == LAST_SLOT);
   always_comb begin
      probe_done = 1'b0;
      if (state_ff == lph_pkg::S_PROBE && rd_vld_ff) begin
         if (!ent_used || lap_done) begin
            probe_done = 1'b1;
         end else if (cmd_ff == lph_pkg::CMD_SEARCH && ent_key == key_ff) begin
            probe_done = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lph_pkg::S_INIT: begin
            if (sweep_done) state_in = lph_pkg::S_IDLE;
         end
         lph_pkg::S_IDLE: begin
            if (req_acc) begin
               case (req_data.command)
                  lph_pkg::CMD_INSERT: state_in = lph_pkg::S_MUL_Q;
                  lph_pkg::CMD_SEARCH: state_in = lph_pkg::S_MUL_Q;
                  lph_pkg::CMD_CLEAR:  state_in = lph_pkg::S_CLEAR;
                  default:             state_in = lph_pkg::S_FLUSH;
               endcase
            end
         end
         lph_pkg::S_MUL_Q: state_in = lph_pkg::S_MUL_R;
         lph_pkg::S_MUL_R: state_in = lph_pkg::S_HOME;
         lph_pkg::S_HOME:  state_in = lph_pkg::S_PROBE;
         lph_pkg::S_PROBE: begin
            if (probe_done) state_in = lph_pkg::S_FLUSH;
         end
         lph_pkg::S_CLEAR: begin
            if (sweep_done) state_in = lph_pkg::S_FLUSH;
         end
         lph_pkg::S_FLUSH: begin
            if (out_free) state_in = lph_pkg::S_IDLE;
         end
         default: state_in = lph_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_slot_in   = rd_slot_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = issue_ff;

      case (state_ff)
         // sweep: clear used bit of one slot per cycle
         lph_pkg::S_INIT, lph_pkg::S_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + SW'(1);
         end
         // capture item, preset the response
         lph_pkg::S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_data.command;
               key_in   = req_data.key;
               value_in = req_data.value;
               cnt_in   = '0;
               res_in.found_value = '0;
               res_in.slot        = '0;
               if (req_data.command == lph_pkg::CMD_CLEAR) begin
                  res_in.status = lph_pkg::STATUS_CLEARED;
               end else begin
                  res_in.status = lph_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         lph_pkg::S_MUL_Q: begin
            q_in = mul_q[62:32];
         end
         lph_pkg::S_MUL_R: begin
            prod_in = RW'(q_ff[RW-1:0] * N_R);
         end
         lph_pkg::S_HOME: begin
            issue_in = home[SW-1:0];
            cnt_in   = '0;
         end
         // probe: read ahead one slot per cycle, check the slot read last cycle
         lph_pkg::S_PROBE: begin
            rd_en      = 1'b1;
            rd_vld_in  = 1'b1;
            rd_slot_in = issue_ff;
            issue_in   = next_slot(issue_ff);
            if (rd_vld_ff) begin
               cnt_in = cnt_ff + SW'(1);
               if (cmd_ff == lph_pkg::CMD_INSERT) begin
                  if (!ent_used) begin
                     wr_en   = 1'b1;
                     wr_addr = rd_slot_ff;
                     wr_data = {1'b1, key_ff, value_ff};
                     res_in.status = lph_pkg::STATUS_INSERTED;
                     res_in.slot   = lph_pkg::SLOT_W'(rd_slot_ff);
                  end else if (lap_done) begin
                     res_in.status = lph_pkg::STATUS_FULL;
                  end
               end else if (ent_used && ent_key == key_ff) begin
                  res_in.status      = lph_pkg::STATUS_FOUND;
                  res_in.found_value = $signed(ent_value);
                  res_in.slot        = lph_pkg::SLOT_W'(rd_slot_ff);
               end
            end
         end
         // hand the result to the output register
         lph_pkg::S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lph_pkg::S_INIT;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      q_ff       <= q_in;
      prod_ff    <= prod_in;
      issue_ff   <= issue_in;
      rd_slot_ff <= rd_slot_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule

>>> hdl/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lph_checker.sv
// ----------------------------------------------------------------------------
// lph_checker
// Port level checks for the linear probing hash table, bound to the top.
// ----------------------------------------------------------------------------
module lph_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lph_pkg::rsp_type rsp_data
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // status is a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= lph_pkg::STATUS_CLEARED)
      else $error("undefined status");

   // value only on a hit
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lph_pkg::STATUS_FOUND |-> rsp_data.found_value == '0)
      else $error("value on a miss");

   // slot only on insert or hit
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lph_pkg::STATUS_FOUND
         && rsp_data.status != lph_pkg::STATUS_INSERTED |-> rsp_data.slot == '0)
      else $error("slot on a miss");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);

>>> tb/sv/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. A short directed
// list covers the empty table, wrap past the last slot, duplicate keys, a
// full table, a full-lap miss, clear and the unused command. Random episodes
// follow, built from small clustered key pools so probes run long and the
// table fills. Every response is checked against an internal table model or a hand-written answer.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;

   localparam int SLOT_COUNT = lph_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS = 1100;
   localparam int POOL_KEYS = 12;
   localparam int QUIET_LIMIT = 1000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // directed list entry: item, and a hand-written answer where one is given
   typedef struct packed {
      lph_pkg::req_type item;
      logic             typed;
      lph_pkg::rsp_type answer;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lph_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lph_pkg::rsp_type rsp_data;

   // table model
   bit                          slot_taken [SLOT_COUNT];
   logic [lph_pkg::KEY_W-1:0]   slot_key_copy [SLOT_COUNT];
   logic [lph_pkg::VALUE_W-1:0] slot_value_copy [SLOT_COUNT];

   lph_pkg::rsp_type            answers_due [$];
   plan_row_type                plan [$];
   logic [lph_pkg::KEY_W-1:0]   key_pool [POOL_KEYS];
   int unsigned                 key_window;
   int unsigned                 mismatches = 0;
   int unsigned                 items_sent = 0;
   int unsigned                 stall_left = 0;
   int unsigned                 quiet_cycles = 0;
   bit                          calm = 1'b0;

   linear_probe_hash_table #(
      .TABLE_ENTRIES(SLOT_COUNT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle length: mostly none or short, a few long
   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // model of one command; updates the table copy
   function automatic lph_pkg::rsp_type table_answer(input lph_pkg::req_type item);
      lph_pkg::rsp_type ans;
      int unsigned      pos;
      int unsigned      n;
      bit               settled;
      ans = '0;
      ans.status = lph_pkg::STATUS_NOT_FOUND;
      pos = item.key % SLOT_COUNT;
      settled = 1'b0;
      case (item.command)
         lph_pkg::CMD_INSERT: begin
            ans.status = lph_pkg::STATUS_FULL;
            for (n = 0; n < SLOT_COUNT && !settled; n++) begin
               if (!slot_taken[pos]) begin
                  slot_taken[pos] = 1'b1;
                  slot_key_copy[pos] = item.key;
                  slot_value_copy[pos] = item.value;
                  ans.status = lph_pkg::STATUS_INSERTED;
                  ans.slot = pos[lph_pkg::SLOT_W-1:0];
                  settled = 1'b1;
               end else begin
                  pos = (pos + 1) % SLOT_COUNT;
               end
            end
         end
         lph_pkg::CMD_SEARCH: begin
            for (n = 0; n < SLOT_COUNT && !settled; n++) begin
               if (!slot_taken[pos]) begin
                  settled = 1'b1;
               end else if (slot_key_copy[pos] == item.key) begin
                  ans.status = lph_pkg::STATUS_FOUND;
                  ans.found_value = slot_value_copy[pos];
                  ans.slot = pos[lph_pkg::SLOT_W-1:0];
                  settled = 1'b1;
               end else begin
                  pos = (pos + 1) % SLOT_COUNT;
               end
            end
         end
         lph_pkg::CMD_CLEAR: begin
            // only the used bits go; stale keys stay behind
            for (n = 0; n < SLOT_COUNT; n++) slot_taken[n] = 1'b0;
            ans.status = lph_pkg::STATUS_CLEARED;
         end
         default: ans.status = lph_pkg::STATUS_NOT_FOUND;
      endcase
      return ans;
   endfunction

   function automatic plan_row_type plan_row(input logic [1:0] cmd,
                                             input logic [lph_pkg::KEY_W-1:0] key,
                                             input logic [lph_pkg::VALUE_W-1:0] value,
                                             input bit typed,
                                             input logic [lph_pkg::STATUS_W-1:0] status,
                                             input logic [lph_pkg::VALUE_W-1:0] fval,
                                             input logic [lph_pkg::SLOT_W-1:0] slot);
      plan_row_type row;
      row.item.command = cmd;
      row.item.key = key;
      row.item.value = value;
      row.typed = typed;
      row.answer.status = status;
      row.answer.found_value = fval;
      row.answer.slot = slot;
      return row;
   endfunction

   // keys cluster around a window of home slots; some are the extremes
   function automatic logic [lph_pkg::KEY_W-1:0] fresh_key();
      logic [lph_pkg::KEY_W-1:0] k;
      k = lph_pkg::KEY_W'($urandom);
      case ($urandom_range(0, 19))
         0: k = '0;
         1: k = '1;
         default: k[3:0] = 4'(key_window + $urandom_range(0, 3));
      endcase
      return k;
   endfunction

   function automatic logic [lph_pkg::VALUE_W-1:0] fresh_value();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic lph_pkg::req_type random_item();
      lph_pkg::req_type item;
      int unsigned      pick;
      item.value = fresh_value();
      item.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         item.command = lph_pkg::CMD_INSERT;
      end else if (pick < 46) begin
         item.command = lph_pkg::CMD_INSERT;
         item.key = fresh_key();
      end else if (pick < 84) begin
         item.command = lph_pkg::CMD_SEARCH;
      end else if (pick < 93) begin
         item.command = lph_pkg::CMD_SEARCH;
         item.key = fresh_key();
      end else if (pick < 96) begin
         item.command = CMD_UNUSED;
         item.key = lph_pkg::KEY_W'($urandom);
      end else begin
         item.command = lph_pkg::CMD_CLEAR;
         item.key = lph_pkg::KEY_W'($urandom);
      end
      return item;
   endfunction

   // present one item, hold it until taken, then log its answer
   task automatic send_item(input lph_pkg::req_type item, input bit typed,
                            input lph_pkg::rsp_type typed_answer);
      int unsigned      gap;
      lph_pkg::rsp_type ans;
      gap = calm ? 0 : idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      ans = table_answer(item);
      answers_due.push_back(typed ? typed_answer : ans);
      items_sent++;
   endtask

   // stop offering items and wait for every logged answer to come back
   task automatic wait_drained();
      if (answers_due.size() != 0) begin
         req_valid <= 1'b0;
         while (answers_due.size() != 0) @(posedge clock);
      end
   endtask

   // response stall pattern
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left = stall_left - 1;
      end
   end

   // response check against the oldest logged answer
   always @(posedge clock) begin
      lph_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (answers_due.size() == 0) begin
            $error("unexpected response: status %0d found_value %0d slot %0d",
                   rsp_data.status, rsp_data.found_value, rsp_data.slot);
            mismatches++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.found_value !== want.found_value) begin
               $error("found_value: expected %0d, got %0d",
                      want.found_value, rsp_data.found_value);
               mismatches++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("linear_probe_hash_table_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               k;
      int unsigned      random_start;
      int unsigned      run_len;
      lph_pkg::req_type wipe;

      // empty table, unused command, wrap, duplicates, fill to full, full-lap miss, clear
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'd5, 32'h0, 1'b1,
                              lph_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0));
      plan.push_back(plan_row(CMD_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              lph_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                              lph_pkg::STATUS_INSERTED, 32'h0, 4'd15));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'd15, 32'h8000_0000, 1'b1,
                              lph_pkg::STATUS_INSERTED, 32'h0, 4'd0));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'h0, 1'b0,
                              '0, '0, '0));
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 32'h1234_5678, 1'b1,
                              lph_pkg::STATUS_FOUND, 32'h7FFF_FFFF, 4'd15));
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'd15, 32'h0, 1'b0, '0, '0, '0));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'h2AAA_AAA1, 32'hFFFF_FFFF, 1'b0,
                              '0, '0, '0));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'h5555_5552, 32'h5555_AAAA, 1'b0,
                              '0, '0, '0));
      for (k = 4; k <= 14; k++)
         plan.push_back(plan_row(lph_pkg::CMD_INSERT, lph_pkg::KEY_W'(k),
                                 ~lph_pkg::VALUE_W'(k), 1'b0, '0, '0, '0));
      plan.push_back(plan_row(lph_pkg::CMD_INSERT, 31'h4000_0007, 32'h1, 1'b1,
                              lph_pkg::STATUS_FULL, 32'h0, 4'd0));
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'h4000_0007, 32'h0, 1'b1,
                              lph_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0));
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'd14, 32'h0, 1'b0, '0, '0, '0));
      plan.push_back(plan_row(lph_pkg::CMD_CLEAR, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              lph_pkg::STATUS_CLEARED, 32'h0, 4'd0));
      plan.push_back(plan_row(lph_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 32'h0, 1'b1,
                              lph_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].answer);
      wait_drained();

      // random episodes over small clustered key pools
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 5) == 0) wait_drained();
         key_window = $urandom_range(0, 15);
         foreach (key_pool[i]) key_pool[i] = fresh_key();
         if ($urandom_range(0, 3) != 0) begin
            wipe.command = lph_pkg::CMD_CLEAR;
            wipe.key = lph_pkg::KEY_W'($urandom);
            wipe.value = $urandom;
            send_item(wipe, 1'b0, '0);
         end
         run_len = $urandom_range(4, 60);
         repeat (run_len) send_item(random_item(), 1'b0, '0);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("linear_probe_hash_table_tb: clean");
      else
         $display("linear_probe_hash_table_tb: errors");
      $finish;
   end

endmodule
